// ----- hw/rtl/lse_pkg.sv -----
// Shared types, codes and sizes for the LIFO stack engine.
package lse_pkg;

    // Stack storage size and derived widths
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int WORD_W = 32;

    // Configuration register indexes
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(10);

    // Operation codes
    localparam logic [2:0] FN_PUSH   = 3'd0;
    localparam logic [2:0] FN_POP    = 3'd1;
    localparam logic [2:0] FN_PEEK   = 3'd2;
    localparam logic [2:0] FN_TOP    = 3'd3;
    localparam logic [2:0] FN_BOTTOM = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BADPOS    = 2'd3;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [WORD_W-1:0] value;
        logic [4:0]               position;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        logic [1:0]               status;
        logic                     full_res;
        logic                     empty_res;
        logic [4:0]               depth;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } ram_req_t;

endpackage

// ----- hw/rtl/lse_ram.sv -----
// Single-port synchronous stack memory with registered read data.
module lse_ram (
    input  logic                              clk,
    input  lse_pkg::ram_req_t                 ram_req,
    output logic [lse_pkg::WORD_W-1:0]        rdata
);
    import lse_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    // Write on enable with write strobe, else read and hold the word
    always_ff @(posedge clk)
    begin
        if (ram_req.en)
        begin
            if (ram_req.we)
            begin
                mem[ram_req.addr] <= ram_req.wdata;
            end
            else
            begin
                rdata_reg <= mem[ram_req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lse_core.sv -----
// Stack pointer, operation decode and result register for the LIFO engine.
module lse_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lse_pkg::CAP_W-1:0]      capacity,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  lse_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output lse_pkg::rsp_t                  rsp,
    output lse_pkg::ram_req_t              ram_req,
    input  logic [lse_pkg::WORD_W-1:0]     ram_rdata
);
    import lse_pkg::*;

    typedef enum logic {S_IDLE, S_DONE} state_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             use_mem;
        logic             full_res;
        logic             empty_res;
        logic [CNT_W-1:0] depth;
    } pend_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    pend_t            pend_reg, pend_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             req_fire;
    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] pos_ext;
    logic [CNT_W-1:0] peek_idx;
    logic [CNT_W-1:0] top_idx;
    logic             out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Clamp capacity into 1..DEPTH
    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (int'(capacity) > DEPTH)
        begin
            eff_cap = CNT_W'(DEPTH);
        end
        else
        begin
            eff_cap = CNT_W'(capacity);
        end
    end

    assign pos_ext  = CNT_W'(req.position);
    assign peek_idx = count_reg - pos_ext;
    assign top_idx  = count_reg - CNT_W'(1);

    // Decode the operation, move the pointer, issue the memory access
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pend_next      = pend_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_req        = '0;
        ram_req.wdata  = req.value;

        // Drop a result once taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    pend_next.status  = ST_OK;
                    pend_next.use_mem = 1'b0;
                    case (req.func)
                        FN_PUSH:
                        begin
                            if (count_reg >= eff_cap)
                            begin
                                pend_next.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                ram_req.en   = 1'b1;
                                ram_req.we   = 1'b1;
                                ram_req.addr = count_reg[ADDR_W-1:0];
                                count_next   = count_reg + CNT_W'(1);
                            end
                        end
                        FN_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_req.en        = 1'b1;
                                ram_req.addr      = top_idx[ADDR_W-1:0];
                                pend_next.use_mem = 1'b1;
                                count_next        = top_idx;
                            end
                        end
                        FN_PEEK:
                        begin
                            if (pos_ext == '0 || pos_ext > count_reg)
                            begin
                                pend_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                ram_req.en        = 1'b1;
                                ram_req.addr      = peek_idx[ADDR_W-1:0];
                                pend_next.use_mem = 1'b1;
                            end
                        end
                        FN_TOP:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_req.en        = 1'b1;
                                ram_req.addr      = top_idx[ADDR_W-1:0];
                                pend_next.use_mem = 1'b1;
                            end
                        end
                        FN_BOTTOM:
                        begin
                            if (count_reg == '0)
                            begin
                                pend_next.status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                ram_req.en        = 1'b1;
                                ram_req.addr      = '0;
                                pend_next.use_mem = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_next.status = ST_OK;
                        end
                    endcase
                    pend_next.full_res  = (count_next >= eff_cap);
                    pend_next.empty_res = (count_next == '0);
                    pend_next.depth     = count_next;
                    state_next          = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    // Refused reads give all ones; pushes and spare codes give zero
                    if (pend_reg.use_mem)
                    begin
                        rsp_next.data = ram_rdata;
                    end
                    else if (pend_reg.status == ST_UNDERFLOW || pend_reg.status == ST_BADPOS)
                    begin
                        rsp_next.data = '1;
                    end
                    else
                    begin
                        rsp_next.data = '0;
                    end
                    rsp_next.status    = pend_reg.status;
                    rsp_next.full_res  = pend_reg.full_res;
                    rsp_next.empty_res = pend_reg.empty_res;
                    rsp_next.depth     = 5'(pend_reg.depth);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, pointer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Pointer never passes the storage size
    assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("stack pointer beyond storage");

    // Memory is touched only when a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.en |-> req_fire)
        else $error("memory access outside request accept");

    // A successful push grows the stack by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && ram_req.we) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance pointer");

    // A waiting result blocks any new request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !req_ready)
        else $error("request taken while result pending");

endmodule

// ----- hw/rtl/lifo_stack_engine.sv -----
// Top level of the LIFO stack engine: register port, core and stack memory.
//
//  Port group    Direction  Carries
//  req_*         in         one request word: func, value, position
//  rsp_*         out        one result word: data, status, flags, depth
//  p*            in/out     APB register port, capacity at address 0
//
// Each request is decoded and issues its memory access in S_IDLE; in S_DONE the
// registered read data of the stack memory is loaded into the result register.
// A new request is taken only once the core is back in S_IDLE.
// Reset empties the stack and sets capacity to 10; stored words are left as is.
// A stalled result holds in the output register; the next request is still
// taken and waits in the core until that register frees.
module lifo_stack_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lse_pkg::req_t         req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output lse_pkg::rsp_t         rsp
);
    import lse_pkg::*;

    logic [CAP_W-1:0]  capacity_reg;
    logic              cfg_write;
    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read back
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : '0;

    lse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    lse_ram u_ram (
        .clk     (clk),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

endmodule

// ----- bench/lifo_stack_engine_tb.sv -----
// Self-checking testbench for the LIFO stack engine: directed, random and backpressure tests.
module lifo_stack_engine_tb;
    import lse_pkg::*;

    // Register map and codes the package does not name
    localparam logic [2:0] ADDR_CAPACITY = 3'(4 * REG_CAPACITY);
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
    localparam logic [2:0] FN_SPARE_LO   = 3'd5;
    localparam logic [2:0] FN_SPARE_HI   = 3'd7;
    localparam int         WATCHDOG_CYC  = 2_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;

    // Shadow copy of the stack and its capacity register
    logic signed [WORD_W-1:0] shadow_mem [DEPTH];
    int unsigned              shadow_count = 0;
    logic [CAP_W-1:0]         shadow_cap   = CAPACITY_RESET;

    rsp_t pending_rsp [$];
    int   err_count  = 0;
    bit   idle_on    = 1'b1;
    int   sink_hold  = 0;

    lifo_stack_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        #(10 * WATCHDOG_CYC);
        $display("TEST FAILED");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Compute the result of one request and advance the shadow stack
    function automatic rsp_t stack_predict(req_t r);
        rsp_t        o;
        int unsigned cap;
        cap = shadow_cap;
        if (cap < 1)
            cap = 1;
        if (cap > DEPTH)
            cap = DEPTH;
        o = '0;
        o.status = ST_OK;
        case (r.func)
            FN_PUSH:
            begin
                if (shadow_count >= cap)
                    o.status = ST_OVERFLOW;
                else
                begin
                    shadow_mem[shadow_count] = r.value;
                    shadow_count++;
                end
            end
            FN_POP:
            begin
                if (shadow_count == 0)
                begin
                    o.data   = -1;
                    o.status = ST_UNDERFLOW;
                end
                else
                begin
                    shadow_count--;
                    o.data = shadow_mem[shadow_count];
                end
            end
            FN_PEEK:
            begin
                if (r.position == 0 || r.position > shadow_count)
                begin
                    o.data   = -1;
                    o.status = ST_BADPOS;
                end
                else
                    o.data = shadow_mem[shadow_count - r.position];
            end
            FN_TOP, FN_BOTTOM:
            begin
                if (shadow_count == 0)
                begin
                    o.data   = -1;
                    o.status = ST_UNDERFLOW;
                end
                else if (r.func == FN_TOP)
                    o.data = shadow_mem[shadow_count - 1];
                else
                    o.data = shadow_mem[0];
            end
            default: ;
        endcase
        o.full_res  = (shadow_count >= cap);
        o.empty_res = (shadow_count == 0);
        o.depth     = 5'(shadow_count);
        return o;
    endfunction

    function automatic req_t mk_req(logic [2:0] f, logic signed [31:0] v, logic [4:0] p);
        req_t r;
        r.func     = f;
        r.value    = v;
        r.position = p;
        return r;
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_word(req_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        pending_rsp.push_back(stack_predict(r));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Two-phase register write; lands at the access-cycle edge
    task automatic apb_write(logic [2:0] addr, logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_CAPACITY)
            shadow_cap = wdata[CAP_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Random request; push share sets whether the stack tends to fill or drain
    function automatic req_t rand_req(int push_pct);
        int          r;
        logic [2:0]  f;
        logic [31:0] v;
        logic [4:0]  p;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            f = FN_PUSH;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                f = FN_POP;
            else if (r < 70)
                f = FN_PEEK;
            else if (r < 82)
                f = FN_TOP;
            else if (r < 94)
                f = FN_BOTTOM;
            else
                f = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        end
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'hFFFF_FFFF;
            3:       v = 32'h0;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 9) < 7)
            p = 5'($urandom_range(1, (shadow_count > 0) ? shadow_count + 1 : 1));
        else
            p = 5'($urandom_range(0, 31));
        return mk_req(f, v, p);
    endfunction

    // Result side: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            if (sink_hold > 0)
            begin
                n = sink_hold;
                sink_hold = 0;
                rsp_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 99) < 20)
            begin
                rsp_ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result word with nothing expected: %h", rsp);
                err_count++;
            end
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (rsp.data !== exp_rsp.data)
                begin
                    $error("data: expected %0d, got %0d", exp_rsp.data, rsp.data);
                    err_count++;
                end
                if (rsp.status !== exp_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                    err_count++;
                end
                if (rsp.full_res !== exp_rsp.full_res)
                begin
                    $error("full_res: expected %0b, got %0b", exp_rsp.full_res, rsp.full_res);
                    err_count++;
                end
                if (rsp.empty_res !== exp_rsp.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", exp_rsp.empty_res,
                           rsp.empty_res);
                    err_count++;
                end
                if (rsp.depth !== exp_rsp.depth)
                begin
                    $error("depth: expected %0d, got %0d", exp_rsp.depth, rsp.depth);
                    err_count++;
                end
            end
        end
    end

    // Every read on an empty stack, and the lowest and highest spare function codes
    task automatic test_empty_stack();
        send_word(mk_req(FN_POP, 32'd5, 5'd0));
        send_word(mk_req(FN_TOP, 32'd0, 5'd0));
        send_word(mk_req(FN_BOTTOM, 32'd0, 5'd0));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd0));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd1));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd31));
        send_word(mk_req(FN_SPARE_LO, 32'h7FFF_FFFF, 5'd16));
        send_word(mk_req(FN_SPARE_HI, 32'h8000_0000, 5'd1));
        drain();
    endtask

    // Overflow, peek limits and underflow with a capacity of two
    task automatic test_bounds();
        apb_write(ADDR_UNMAPPED, 32'd3);
        apb_write(ADDR_CAPACITY, 32'd2);
        send_word(mk_req(FN_PUSH, 32'h8000_0000, 5'd0));
        send_word(mk_req(FN_PUSH, 32'h7FFF_FFFF, 5'd31));
        send_word(mk_req(FN_PUSH, 32'd0, 5'd0));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd1));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd2));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd3));
        send_word(mk_req(FN_PEEK, 32'd0, 5'd16));
        send_word(mk_req(FN_TOP, 32'd0, 5'd0));
        send_word(mk_req(FN_BOTTOM, 32'd0, 5'd0));
        send_word(mk_req(FN_SPARE_HI, 32'd0, 5'd0));
        send_word(mk_req(FN_POP, 32'd0, 5'd0));
        send_word(mk_req(FN_POP, 32'd0, 5'd0));
        send_word(mk_req(FN_POP, 32'd0, 5'd0));
        drain();
    endtask

    // Random mix over a series of capacities; the stack carries over between them
    task automatic test_random_mix();
        logic [CAP_W-1:0] caps [11] = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd2, 5'd7,
                                        5'd17, 5'd10, 5'd4, 5'd13, 5'd16};
        int push_pct;
        foreach (caps[k])
        begin
            drain();
            apb_write(ADDR_CAPACITY, 32'(caps[k]));
            for (int i = 0; i < 150; i++)
            begin
                if (i % 25 == 0)
                    push_pct = $urandom_range(15, 70);
                if (i % 50 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                send_word(rand_req(push_pct));
            end
        end
        idle_on = 1'b1;
        drain();
    endtask

    // Hold off the result side while requests keep coming
    task automatic test_backpressure();
        apb_write(ADDR_CAPACITY, 32'd16);
        idle_on   = 1'b0;
        sink_hold = 300;
        for (int i = 0; i < 40; i++)
            send_word(rand_req(60));
        idle_on = 1'b1;
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_stack();
        test_bounds();
        test_random_mix();
        test_backpressure();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
